// ===== design/bptc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and weight tables of the BC7 texel interpolator.
// No dependencies.
package bptc_pkg;

    localparam int TEXELS_PER_BLOCK = 16;
    localparam int SUBSET_COUNT     = 3;
    localparam int TEXEL_W          = 4;
    localparam int SUBSET_W         = 2;
    localparam int WEIGHT_W         = 7;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [1:0] {
        WT_2BIT = 2'd0,
        WT_3BIT = 2'd1,
        WT_4BIT = 2'd2
    } t_wt_code;

    typedef struct packed {
        logic [2:0]  index_width;
        logic        has_alpha;
        logic [1:0]  rotation;
        logic        is_partitioned;
        logic [63:0] texel_indices;
        logic [31:0] subset_map;
        logic [63:0] subset0_endpoints;
        logic [63:0] subset1_endpoints;
        logic [63:0] subset2_endpoints;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [TEXEL_W-1:0] texel_number;
        logic               last_texel;
    } t_out_item;

    typedef struct packed {
        t_wt_code                      code;
        logic                          has_alpha;
        logic [1:0]                    rotation;
        logic                          is_partitioned;
        logic [63:0]                   texel_indices;
        logic [31:0]                   subset_map;
        logic [SUBSET_COUNT-1:0][63:0] endpoints;
    } t_block;

    function automatic logic [WEIGHT_W-1:0] bptc_weight(t_wt_code code, logic [3:0] idx);
        logic [WEIGHT_W-1:0] w;
        w = '0;
        case (code)
            WT_2BIT: begin
                case (idx[1:0])
                    2'd0:    w = 7'd0;
                    2'd1:    w = 7'd21;
                    2'd2:    w = 7'd43;
                    default: w = 7'd64;
                endcase
            end
            WT_3BIT: begin
                case (idx[2:0])
                    3'd0:    w = 7'd0;
                    3'd1:    w = 7'd9;
                    3'd2:    w = 7'd18;
                    3'd3:    w = 7'd27;
                    3'd4:    w = 7'd37;
                    3'd5:    w = 7'd46;
                    3'd6:    w = 7'd55;
                    default: w = 7'd64;
                endcase
            end
            default: begin
                case (idx)
                    4'd0:    w = 7'd0;
                    4'd1:    w = 7'd4;
                    4'd2:    w = 7'd9;
                    4'd3:    w = 7'd13;
                    4'd4:    w = 7'd17;
                    4'd5:    w = 7'd21;
                    4'd6:    w = 7'd26;
                    4'd7:    w = 7'd30;
                    4'd8:    w = 7'd34;
                    4'd9:    w = 7'd38;
                    4'd10:   w = 7'd43;
                    4'd11:   w = 7'd47;
                    4'd12:   w = 7'd51;
                    4'd13:   w = 7'd55;
                    4'd14:   w = 7'd60;
                    default: w = 7'd64;
                endcase
            end
        endcase
        return w;
    endfunction

endpackage

// ===== design/bptc_block_texel_interpolator.sv =====
`timescale 1ns / 1ps
// Top level of the BC7 texel interpolator: block queue front end and texel back end.
// Depends on bptc_pkg, bptc_front, bptc_back.
//
//  channel   handshake          payload     transaction
//  input     i_push / o_full    i_item      one parsed BC7 block
//  output    o_empty / i_pop    o_result    one RGBA texel, sixteen per block
//
// One texel per cycle leaves the back end unless its result queue is full and not popped; the
// back end's texel counter sets this rate. The block queue holds two blocks,
// the one being worked on included.
// A block is registered in the block queue, then its first texel in the result queue.
// Synchronous active-low reset empties both queues and clears the counter.
// Output stalls hold the back end; input is refused only when the block queue is full.
module bptc_block_texel_interpolator
    import bptc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_item  i_item,
    output logic      o_full,
    output logic      o_empty,
    output t_out_item o_result,
    input  logic      i_pop
);

    logic   w_blk_valid;
    logic   w_blk_take;
    t_block w_blk;

    bptc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .o_blk_valid (w_blk_valid),
        .o_blk       (w_blk),
        .i_blk_take  (w_blk_take)
    );

    bptc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk_valid (w_blk_valid),
        .i_blk       (w_blk),
        .o_blk_take  (w_blk_take),
        .o_empty     (o_empty),
        .o_result    (o_result),
        .i_pop       (i_pop)
    );

`ifndef SYNTH
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_blk_take |-> w_blk_valid)
        else $error("block released while none queued");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_result.last_texel == (o_result.texel_number == 4'd15)))
        else $error("last texel mark mismatch");

    a_texel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !o_result.last_texel) |=>
        (o_empty || o_result.texel_number == $past(o_result.texel_number) + 4'd1))
        else $error("texel order broken");
`endif

endmodule

// ===== design/bptc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts blocks, decodes the weight table code and queues them.
// Depends on bptc_pkg.
module bptc_front
    import bptc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_blk_valid,
    output t_block   o_blk,
    input  logic     i_blk_take
);

    logic [1:0] r_cnt, n_cnt;
    logic       r_wptr, r_rptr;
    t_block     r_mem [QUEUE_DEPTH];
    t_block     w_dec;
    logic       w_wr, w_rd;

    always_comb begin
        w_dec.code           = (i_item.index_width <= 3'd2) ? WT_2BIT :
                               (i_item.index_width == 3'd3) ? WT_3BIT : WT_4BIT;
        w_dec.has_alpha      = i_item.has_alpha;
        w_dec.rotation       = i_item.rotation;
        w_dec.is_partitioned = i_item.is_partitioned;
        w_dec.texel_indices  = i_item.texel_indices;
        w_dec.subset_map     = i_item.subset_map;
        w_dec.endpoints[0]   = i_item.subset0_endpoints;
        w_dec.endpoints[1]   = i_item.subset1_endpoints;
        w_dec.endpoints[2]   = i_item.subset2_endpoints;
    end

    assign o_full      = (r_cnt == 2'(QUEUE_DEPTH));
    assign o_blk_valid = (r_cnt != 2'd0);
    assign o_blk       = r_mem[r_rptr];
    assign w_wr        = i_push & ~o_full;
    assign w_rd        = i_blk_take & o_blk_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr & ~w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_rd & ~w_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wptr <= ~r_wptr;
            end
            if (w_rd) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= w_dec;
        end
    end

endmodule

// ===== design/bptc_back.sv =====
`timescale 1ns / 1ps
// Back end: walks the sixteen texels of the head block, interpolates and
// rotates, and queues the results. Depends on bptc_pkg.
module bptc_back
    import bptc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_blk_valid,
    input  t_block    i_blk,
    output logic      o_blk_take,
    output logic      o_empty,
    output t_out_item o_result,
    input  logic      i_pop
);

    logic [TEXEL_W-1:0]  r_texel;
    logic [1:0]          r_cnt, n_cnt;
    logic                r_wptr, r_rptr;
    t_out_item           r_mem [QUEUE_DEPTH];
    t_out_item           w_res;
    logic                w_issue, w_rd, w_last;
    logic [3:0]          w_idx;
    logic [WEIGHT_W-1:0] w_wt;
    logic [SUBSET_W-1:0] w_sub;
    logic [63:0]         w_ep;
    logic [7:0]          w_c [4];
    logic [7:0]          w_tmp;

    function automatic logic [7:0] lerp(logic [7:0] e0, logic [7:0] e1,
                                        logic [WEIGHT_W-1:0] w);
        logic [14:0] p0;
        logic [14:0] p1;
        logic [15:0] s;
        p0 = 15'(e0) * 15'(7'd64 - w);
        p1 = 15'(e1) * 15'(w);
        s  = 16'(p0) + 16'(p1) + 16'd32;
        return s[13:6];
    endfunction

    assign w_last = (r_texel == TEXEL_W'(TEXELS_PER_BLOCK - 1));
    assign w_rd   = i_pop & ~o_empty;
    assign w_issue = i_blk_valid & ((r_cnt != 2'(QUEUE_DEPTH)) | w_rd);
    assign o_blk_take = w_issue & w_last;
    assign o_empty  = (r_cnt == 2'd0);
    assign o_result = r_mem[r_rptr];

    always_comb begin
        w_idx = i_blk.texel_indices[4*r_texel +: 4];
        w_wt  = bptc_weight(i_blk.code, w_idx);
        w_sub = '0;
        if (i_blk.is_partitioned) begin
            w_sub = i_blk.subset_map[SUBSET_W*r_texel +: SUBSET_W];
            if (w_sub >= SUBSET_W'(SUBSET_COUNT)) begin
                w_sub = SUBSET_W'(SUBSET_COUNT - 1);
            end
        end
        w_ep = i_blk.endpoints[w_sub];
        for (int ch = 0; ch < 4; ch++) begin
            w_c[ch] = lerp(w_ep[8*ch +: 8], w_ep[32+8*ch +: 8], w_wt);
        end
        if (!i_blk.has_alpha) begin
            w_c[3] = 8'd255;
        end
        w_tmp = w_c[3];
        case (i_blk.rotation)
            2'd1: begin
                w_c[3] = w_c[0];
                w_c[0] = w_tmp;
            end
            2'd2: begin
                w_c[3] = w_c[1];
                w_c[1] = w_tmp;
            end
            2'd3: begin
                w_c[3] = w_c[2];
                w_c[2] = w_tmp;
            end
            default: begin
                w_c[3] = w_tmp;
            end
        endcase
        w_res.red          = w_c[0];
        w_res.green        = w_c[1];
        w_res.blue         = w_c[2];
        w_res.alpha        = w_c[3];
        w_res.texel_number = r_texel;
        w_res.last_texel   = w_last;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_issue & ~w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_rd & ~w_issue) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_texel <= '0;
            r_cnt   <= '0;
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_issue) begin
                r_texel <= r_texel + TEXEL_W'(1);
                r_wptr  <= ~r_wptr;
            end
            if (w_rd) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_mem[r_wptr] <= w_res;
        end
    end

endmodule
